// ----- design/slcd_pkg.sv -----
// ----------------------------------------------------------------------------
// slcd_pkg - shared types and constants of the serial line command decoder
// Command texts, reply messages, the job record passed from front to back.
// ----------------------------------------------------------------------------
package slcd_pkg;

  localparam int LINE_LEN_DEF = 16;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  // command table: LRON LROFF LGON LGOFF LBON LBOFF (short ones space padded)
  localparam int NUM_CMD   = 6;
  localparam int CMD_CHARS = 5;
  localparam int CMD_SHORT = 4;
  localparam logic [8*CMD_CHARS-1:0] CMD_TEXT [NUM_CMD] = '{
    "LRON ", "LROFF", "LGON ", "LGOFF", "LBON ", "LBOFF"
  };

  // reply messages, first character in the top byte
  localparam int LONG_LEN = 15;
  localparam int BAD_LEN  = 11;
  localparam logic [8*LONG_LEN-1:0] MSG_LONG = "Zbyt dlugi ciag";
  localparam logic [8*BAD_LEN-1:0]  MSG_BAD  = "Zla komenda";

  // index over the transactions of one reply (longest is 17)
  localparam int IDX_W = 5;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    JOB_LED  = 2'd0,
    JOB_BAD  = 2'd1,
    JOB_LONG = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [1:0] led_sel;
    logic       led_on;
  } job_t;

  // character p of command c
  function automatic logic [7:0] cmd_char(input int c, input logic [2:0] p);
    logic [8*CMD_CHARS-1:0] txt;
    txt = CMD_TEXT[c] >> (8 * (CMD_CHARS - 1 - int'(p)));
    return txt[7:0];
  endfunction

  function automatic int cmd_size(input int c);
    return (c % 2 == 1) ? CMD_CHARS : CMD_SHORT;
  endfunction

  // message length without the LF, CR tail
  function automatic logic [IDX_W-1:0] msg_len(input job_kind_t k);
    return (k == JOB_LONG) ? IDX_W'(LONG_LEN) : IDX_W'(BAD_LEN);
  endfunction

  // byte idx of a reply: text, then LF, then CR
  function automatic logic [7:0] msg_byte(input job_kind_t k, input logic [IDX_W-1:0] idx);
    logic [8*LONG_LEN-1:0] lng;
    logic [8*BAD_LEN-1:0]  bad;
    logic [IDX_W-1:0]      len;
    logic [7:0]            ch;
    len = msg_len(k);
    lng = MSG_LONG >> (8 * (LONG_LEN - 1 - int'(idx)));
    bad = MSG_BAD  >> (8 * (BAD_LEN  - 1 - int'(idx)));
    if (idx < len) begin
      ch = (k == JOB_LONG) ? lng[7:0] : bad[7:0];
    end else if (idx == len) begin
      ch = CH_LF;
    end else begin
      ch = CH_CR;
    end
    return ch;
  endfunction

endpackage

// ----- design/slcd_front.sv -----
// ----------------------------------------------------------------------------
// slcd_front - line collector and classifier
// Tracks the line byte by byte against the command table; on CR posts a job.
// ----------------------------------------------------------------------------
module slcd_front #(
  parameter int LINE_LEN = slcd_pkg::LINE_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  output logic           in_ready,
  output logic           push,
  output slcd_pkg::job_t push_job,
  input  logic           q_full
);

  localparam int CNT_W = $clog2(LINE_LEN + 1);

  logic [CNT_W-1:0]             fill_r, fill_nxt;
  logic [CNT_W-1:0]             zlen_r, zlen_nxt;
  logic                         zero_r, zero_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [slcd_pkg::NUM_CMD-1:0] match_r, match_nxt;
  logic                         acc;
  logic [CNT_W-1:0]             len;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign len      = zero_r ? zlen_r : fill_r;

  always_comb begin
    fill_nxt  = fill_r;
    zlen_nxt  = zlen_r;
    zero_nxt  = zero_r;
    ovf_nxt   = ovf_r;
    match_nxt = match_r;
    push      = 1'b0;
    push_job  = '{kind: slcd_pkg::JOB_BAD, led_sel: 2'd0, led_on: 1'b0};
    if (acc) begin
      if (in_byte == slcd_pkg::CH_CR) begin
        push = 1'b1;
        if (ovf_r) begin
          push_job.kind = slcd_pkg::JOB_LONG;
        end else begin
          for (int c = slcd_pkg::NUM_CMD - 1; c >= 0; c--) begin
            if (match_r[c] && len == CNT_W'(slcd_pkg::cmd_size(c))) begin
              push_job.kind    = slcd_pkg::JOB_LED;
              push_job.led_sel = 2'(c / 2);
              push_job.led_on  = (c % 2 == 0);
            end
          end
        end
        fill_nxt  = '0;
        zero_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
        match_nxt = '1;
      end else if (!ovf_r) begin
        if (!zero_r) begin
          if (in_byte == 8'd0) begin
            zero_nxt = 1'b1;
            zlen_nxt = fill_r;
          end else begin
            for (int c = 0; c < slcd_pkg::NUM_CMD; c++) begin
              if (!(fill_r < CNT_W'(slcd_pkg::cmd_size(c)) &&
                    in_byte == slcd_pkg::cmd_char(c, fill_r[2:0]))) begin
                match_nxt[c] = 1'b0;
              end
            end
          end
        end
        fill_nxt = fill_r + 1'b1;
        if (fill_nxt == CNT_W'(LINE_LEN)) begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      zero_r  <= 1'b0;
      ovf_r   <= 1'b0;
      match_r <= '1;
    end else begin
      fill_r  <= fill_nxt;
      zero_r  <= zero_nxt;
      ovf_r   <= ovf_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zlen_r <= zlen_nxt;
  end

endmodule

// ----- design/slcd_queue.sv -----
// ----------------------------------------------------------------------------
// slcd_queue - short job queue between front and back
// Register based FIFO of slcd_pkg::QUEUE_DEPTH entries.
// ----------------------------------------------------------------------------
module slcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slcd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output slcd_pkg::job_t pop_job
);

  localparam int PTR_W = $clog2(slcd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(slcd_pkg::QUEUE_DEPTH + 1);

  slcd_pkg::job_t   mem_r [slcd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = cnt_r == CNT_W'(slcd_pkg::QUEUE_DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_job   = mem_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PTR_W'(slcd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(slcd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

// ----- design/slcd_back.sv -----
// ----------------------------------------------------------------------------
// slcd_back - reply sequencer
// Expands one job into its output transactions through an output register.
// ----------------------------------------------------------------------------
module slcd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  slcd_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic           out_kind,
  output logic [1:0]     out_led_sel,
  output logic           out_led_on,
  output logic [7:0]     out_tx_byte,
  output logic           out_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } st_t;

  st_t                            st_r, st_nxt;
  slcd_pkg::job_t                 job_r;
  logic [slcd_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                           vld_r, vld_nxt;
  logic                           kind_r, on_r, last_r;
  logic [1:0]                     sel_r;
  logic [7:0]                     tx_r;
  logic                           slot;
  logic                           gen;
  logic                           g_last;

  assign slot  = !vld_r || out_tready;
  assign gen   = (st_r == ST_RUN) && slot;
  assign q_pop = (st_r == ST_IDLE) && q_not_empty;
  assign g_last = (job_r.kind == slcd_pkg::JOB_LED) ||
                  (idx_r == slcd_pkg::msg_len(job_r.kind) + 1'b1);

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    vld_nxt = vld_r && !out_tready;
    unique case (st_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          st_nxt  = ST_RUN;
          idx_nxt = '0;
        end
      end
      ST_RUN: begin
        if (gen) begin
          vld_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (g_last) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      vld_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (q_pop) begin
      job_r <= q_job;
    end
    if (gen) begin
      last_r <= g_last;
      if (job_r.kind == slcd_pkg::JOB_LED) begin
        kind_r <= 1'b0;
        sel_r  <= job_r.led_sel;
        on_r   <= job_r.led_on;
        tx_r   <= 8'd0;
      end else begin
        kind_r <= 1'b1;
        sel_r  <= 2'd0;
        on_r   <= 1'b0;
        tx_r   <= slcd_pkg::msg_byte(job_r.kind, idx_r);
      end
    end
  end

  assign out_tvalid  = vld_r;
  assign out_kind    = kind_r;
  assign out_led_sel = sel_r;
  assign out_led_on  = on_r;
  assign out_tx_byte = tx_r;
  assign out_last    = last_r;

endmodule

// ----- design/serial_line_command_decoder_core.sv -----
// ----------------------------------------------------------------------------
// serial_line_command_decoder_core - serial command line decoder
// Collects received bytes into a command line; on CR emits an LED action or
// a text reply (too long / unknown command) followed by LF, CR.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata[7:0] rx_byte
//  out_    | out | out_tvalid/out_tready| tuser kind, tdata led_select,
//          |     |                      | led_on, tx_byte; tlast last
//
//  Flow: a CR turns a received line into a job in the queue; the back end
//  then emits one transaction a cycle while out_tready stays high (17 for
//  the too-long reply, 13 for the unknown-command reply, 1 for an LED
//  action), and returns to idle to pick the next job off the queue.
//  Stalls: the front stops taking bytes only when the two-entry job queue
//  is full; out_tready low holds the output register and the sequencer.
//  Reset: rst_n, synchronous, clears the line state, queue and sequencer.
//
module serial_line_command_decoder_core #(
  parameter int LINE_LEN = slcd_pkg::LINE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // result transactions
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [1:0] led_select, [2] led_on, [10:3] tx_byte, rest 0
  output logic        out_tuser,   // [0] kind: 0 LED action, 1 byte to transmit
  output logic        out_tlast
);

  logic           push, q_full, q_pop, q_not_empty;
  slcd_pkg::job_t push_job, q_job;
  logic [1:0]     led_sel;
  logic           led_on;
  logic [7:0]     tx_byte;

  // front: line tracking and classification on CR
  slcd_front #(
    .LINE_LEN(LINE_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_ready (in_tready),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // decouples line collection from reply output
  slcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (q_job)
  );

  // back: expands a job into its transactions
  slcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_kind    (out_tuser),
    .out_led_sel (led_sel),
    .out_led_on  (led_on),
    .out_tx_byte (tx_byte),
    .out_last    (out_tlast)
  );

  assign out_tdata = {5'd0, tx_byte, led_on, led_sel};

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for serial_line_command_decoder_core
// Streams received bytes into the decoder: command lines, near misses, lines
// with embedded zero bytes, full and overlong lines, and noise. A scoreboard
// keeps its own copy of the line state, predicts each reply and checks every
// result transaction in order. Both sides idle in short random bursts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LINE_LEN       = slcd_pkg::LINE_LEN_DEF;
  localparam int NUM_WORDS      = 6;
  localparam int RAND_ITEMS     = 370;
  localparam int QUIET_ITEMS    = 60;   // last stretch without idling
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int REPORT_MAX     = 10;

  localparam logic KIND_LED = 1'b0;
  localparam logic KIND_TX  = 1'b1;

  typedef enum logic [1:0] {
    LED_RED   = 2'd0,
    LED_GREEN = 2'd1,
    LED_BLUE  = 2'd2
  } led_t;

  typedef struct packed {
    logic       kind;
    led_t       led_sel;
    logic       led_on;
    logic [7:0] tx;
    logic       last;
  } reply_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the line state and queues the predicted replies
  // --------------------------------------------------------------------------
  class reply_scoreboard;
    logic [7:0]  line_buf [LINE_LEN];
    int unsigned line_fill;
    bit          line_over;
    reply_t      replies_due [$];
    int unsigned mismatches;
    int unsigned rx_count;
    int unsigned reply_count;
    int unsigned led_lines;
    int unsigned bad_lines;
    int unsigned long_lines;

    function new();
      line_fill   = 0;
      line_over   = 0;
      mismatches  = 0;
      rx_count    = 0;
      reply_count = 0;
      led_lines   = 0;
      bad_lines   = 0;
      long_lines  = 0;
    endfunction

    static function string cmd_word(int idx);
      case (idx)
        0:       return "LRON";
        1:       return "LROFF";
        2:       return "LGON";
        3:       return "LGOFF";
        4:       return "LBON";
        default: return "LBOFF";
      endcase
    endfunction

    // text reply, then LF, then CR carrying last
    function void queue_text(string s);
      reply_t r;
      for (int i = 0; i < s.len(); i++) begin
        r = '{KIND_TX, LED_RED, 1'b0, s[i], 1'b0};
        replies_due.push_back(r);
      end
      r = '{KIND_TX, LED_RED, 1'b0, slcd_pkg::CH_LF, 1'b0};
      replies_due.push_back(r);
      r = '{KIND_TX, LED_RED, 1'b0, slcd_pkg::CH_CR, 1'b1};
      replies_due.push_back(r);
    endfunction

    // line text is taken up to the first zero byte, as a C string
    function int match_word();
      int    len;
      int    hit;
      bit    same;
      string w;
      len = 0;
      hit = -1;
      while (len < line_fill && line_buf[len] != 8'h00) len++;
      for (int c = 0; c < NUM_WORDS && hit < 0; c++) begin
        w = cmd_word(c);
        if (w.len() == len) begin
          same = 1;
          for (int i = 0; i < len; i++) begin
            if (line_buf[i] != w[i]) same = 0;
          end
          if (same) hit = c;
        end
      end
      return hit;
    endfunction

    function void take_rx_byte(logic [7:0] b);
      int     hit;
      reply_t r;
      rx_count++;
      if (b != slcd_pkg::CH_CR) begin
        if (!line_over && line_fill < LINE_LEN) begin
          line_buf[line_fill] = b;
          line_fill++;
          if (line_fill >= LINE_LEN) line_over = 1;
        end
      end else begin
        if (line_over) begin
          queue_text("Zbyt dlugi ciag");
          long_lines++;
        end else begin
          hit = match_word();
          if (hit >= 0) begin
            r = '{KIND_LED, led_t'(hit / 2), (hit % 2 == 0), 8'h00, 1'b1};
            replies_due.push_back(r);
            led_lines++;
          end else begin
            queue_text("Zla komenda");
            bad_lines++;
          end
        end
        line_fill = 0;
        line_over = 0;
      end
    endfunction

    function void check_reply(logic kind, logic [15:0] data, logic last);
      reply_t want;
      bit     bad;
      reply_count++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result kind %0d data %04h last %0d",
                   $realtime, kind, data, last);
      end else begin
        want = replies_due.pop_front();
        bad  = (kind !== want.kind) || (data[1:0] !== want.led_sel) ||
               (data[2] !== want.led_on) || (data[10:3] !== want.tx) ||
               (data[15:11] !== 5'd0) || (last !== want.last);
        if (bad) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"%0t: result mismatch, expected kind %0d led %0d on %0d tx %02h",
                      " last %0d pad 00, got kind %0d led %0d on %0d tx %02h last %0d",
                      " pad %02h"},
                     $realtime, want.kind, want.led_sel, want.led_on, want.tx,
                     want.last, kind, data[1:0], data[2], data[10:3], last,
                     data[15:11]);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and shared state
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  reply_scoreboard board = new();
  logic [7:0]      line_bytes [$];
  bit              quiet   = 0;
  bit              tx_calm = 0;
  bit              rx_calm = 0;
  int              rdy_hold = 0;

  always #10 clk = ~clk;

  serial_line_command_decoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // result side: sample at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_reply(out_tuser, out_tdata, out_tlast);
  end

  // receiver stalls: random bursts of out_tready low, with calm stretches
  always @(negedge clk) begin
    if (rdy_hold > 0) begin
      rdy_hold--;
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (rst_n && !quiet && !rx_calm && $urandom_range(0, 3) == 0) begin
        rdy_hold = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any transaction on either side
  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stale = 0;
      else stale++;
    end
    $display("serial_line_command_decoder_core test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    board.take_rx_byte(b);
  endtask

  // sends the queued line bytes, optionally closed by CR
  task automatic send_queued(bit close_line);
    while (line_bytes.size() != 0) send_byte(line_bytes.pop_front());
    if (close_line) send_byte(slcd_pkg::CH_CR);
  endtask

  task automatic queue_word(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == slcd_pkg::CH_CR) b = 8'hff;
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned sent;
    int          pick;
    int          word;
    int          target;
    int          pos;
    logic [7:0]  b;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty line
    send_byte(slcd_pkg::CH_CR);
    // zero byte ends the text early, the rest of the line is ignored
    queue_word("LBON");
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hff);
    send_queued(1);
    // exactly LINE_LEN bytes before CR counts as too long
    queue_word("LGOFF");
    for (int i = 5; i < LINE_LEN; i++) line_bytes.push_back(8'(8'h75 + 2 * i));
    send_queued(1);

    // random lines, mostly well formed
    sent = 0;
    while (sent < RAND_ITEMS) begin
      quiet = (sent >= RAND_ITEMS - QUIET_ITEMS);
      pick  = $urandom_range(0, 99);
      word  = $urandom_range(0, NUM_WORDS - 1);
      queue_word(reply_scoreboard::cmd_word(word));
      if (pick < 45) begin
        // plain command
      end else if (pick < 55) begin
        // command, zero byte, random tail
        line_bytes.push_back(8'h00);
        repeat ($urandom_range(0, 8)) line_bytes.push_back(plain_byte());
      end else if (pick < 70) begin
        // near miss
        pos = $urandom_range(0, line_bytes.size() - 1);
        case ($urandom_range(0, 3))
          0: line_bytes[pos] = plain_byte();
          1: void'(line_bytes.pop_back());
          2: line_bytes.push_back(plain_byte());
          default: line_bytes[pos] = line_bytes[pos] | 8'h20;
        endcase
      end else if (pick < 85) begin
        // arbitrary bytes, a CR among them ends the line early
        line_bytes.delete();
        repeat ($urandom_range(0, 20)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        // around the buffer length
        case ($urandom_range(0, 2))
          0:       target = LINE_LEN - 1;
          1:       target = LINE_LEN;
          default: target = LINE_LEN + $urandom_range(1, 8);
        endcase
        if ($urandom_range(0, 1) == 0) line_bytes[line_bytes.size() - 1] = 8'h00;
        while (line_bytes.size() < target) line_bytes.push_back(plain_byte());
      end else begin
        // unterminated noise, merges into the next line
        line_bytes.delete();
        repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      sent += line_bytes.size() + ((pick < 95) ? 1 : 0);
      send_queued(pick < 95);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;

    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d received bytes: %0d LED commands, %0d unknown and %0d overlong lines.",
             board.rx_count, board.led_lines, board.bad_lines, board.long_lines);
    $display("Checked %0d result transactions, %0d mismatches, %0d replies outstanding.",
             board.reply_count, board.mismatches, board.replies_due.size());
    if (board.mismatches == 0 && board.replies_due.size() == 0) begin
      $display("serial_line_command_decoder_core test passed");
    end else begin
      $display("serial_line_command_decoder_core test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/slcd_pkg.sv
design/slcd_front.sv
design/slcd_queue.sv
design/slcd_back.sv
design/serial_line_command_decoder_core.sv
bench/testbench.sv
